[sv/assert_macros.svh]
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define WSPM_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`define WSPM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define WSPM_ASSERT(lbl, cond)

`define WSPM_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

[sv/wspm_pkg.sv]
package wspm_pkg;

    localparam int WHEELS_DEF = 4;

    localparam int PERIOD_W = 32;
    localparam int PSC_W    = 16;
    localparam int TEETH_W  = 8;
    localparam int WHEEL_W  = 2;
    localparam int CAP_W    = 32;
    localparam int FREQ_W   = 27;
    localparam int RPM_W    = 33;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEETH_COUNT  = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 32'd65535;
    localparam logic [PSC_W-1:0]    PSC_RST    = 16'd0;
    localparam logic [TEETH_W-1:0]  TEETH_RST  = 8'd1;

    localparam logic [FREQ_W-1:0] CLOCK_HZ = 27'd96000000;

    localparam logic FUNC_CAPTURE  = 1'b0;
    localparam logic FUNC_OVERFLOW = 1'b1;

    // job kinds handed from front to back
    localparam logic [1:0] K_OVF      = 2'd0;
    localparam logic [1:0] K_CAP_KEEP = 2'd1;
    localparam logic [1:0] K_CAP_CALC = 2'd2;

    localparam logic [1:0] OVC_MAX    = 2'd3;
    localparam logic [1:0] STOP_LIMIT = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int DIV_W     = 34;
    localparam int DIVISOR_W = 32;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [1:0]         kind;
        logic [WHEEL_W-1:0] wheel;
        logic [CAP_W-1:0]   interval;
        logic               stopped;
    } q_entry_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

[sv/wspm_fifo.sv]
`include "assert_macros.svh"

module wspm_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wspm_pkg::q_entry_t  push_data,
    output logic                full,
    input  logic                pop,
    output logic                avail,
    output wspm_pkg::q_entry_t  pop_data
);
    import wspm_pkg::*;

    q_entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign avail    = (cnt_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `WSPM_ASSERT_IMPL(a_no_push_full, full, !push)
    `WSPM_ASSERT_IMPL(a_no_pop_empty, !avail, !pop)

endmodule

[sv/wspm_front.sv]
module wspm_front #(
    parameter int WHEELS = wspm_pkg::WHEELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic [wspm_pkg::WHEEL_W-1:0]      wheel,
    input  logic [wspm_pkg::CAP_W-1:0]        capture_value,
    input  logic [wspm_pkg::PERIOD_W-1:0]     timer_period,
    output logic                              push,
    output wspm_pkg::q_entry_t                push_data,
    input  logic                              full
);
    import wspm_pkg::*;

    localparam int IW = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    logic [CAP_W-1:0] last_reg [WHEELS];
    logic [1:0]       ovc_reg  [WHEELS];

    logic             take;
    logic             in_range;
    logic [IW-1:0]    widx;
    logic [1:0]       ovc;
    logic [1:0]       ovc_inc;
    logic [CAP_W-1:0] interval;

    assign in_ready = !full;
    assign take     = in_valid && !full;
    assign in_range = ({30'd0, wheel} < 32'(WHEELS));
    assign widx     = IW'(wheel);
    assign ovc      = ovc_reg[widx];
    assign ovc_inc  = (ovc == OVC_MAX) ? OVC_MAX : ovc + 2'd1;
    // one overflow adds a period; two or more never reach the divider
    assign interval = capture_value + ((ovc == 2'd1) ? timer_period : '0) - last_reg[widx];

    always_comb
    begin
        push_data.wheel    = wheel;
        push_data.interval = interval;
        if (func == FUNC_OVERFLOW)
        begin
            push_data.kind    = K_OVF;
            push_data.stopped = (ovc_inc >= STOP_LIMIT);
        end
        else
        begin
            push_data.kind    = (interval != '0 && ovc < STOP_LIMIT) ? K_CAP_CALC : K_CAP_KEEP;
            push_data.stopped = 1'b0;
        end
    end

    assign push = take && in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WHEELS; i++)
            begin
                last_reg[i] <= '0;
                ovc_reg[i]  <= '0;
            end
        end
        else if (push)
        begin
            if (func == FUNC_OVERFLOW)
            begin
                ovc_reg[widx] <= ovc_inc;
            end
            else
            begin
                ovc_reg[widx]  <= '0;
                last_reg[widx] <= capture_value;
            end
        end
    end

endmodule

[sv/wspm_div.sv]
module wspm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  wspm_pkg::div_req_t req,
    output wspm_pkg::div_rsp_t rsp
);
    import wspm_pkg::*;

    logic [DIV_W-1:0]     q_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] d_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;

    logic [DIVISOR_W:0]   r1;
    logic [DIVISOR_W:0]   r2;
    logic                 ge1;
    logic                 ge2;
    logic [DIVISOR_W-1:0] r1n;
    logic [DIVISOR_W-1:0] r2n;
    logic [DIV_W-1:0]     q_next;

    // two restoring steps per cycle
    always_comb
    begin
        r1     = {rem_reg, q_reg[DIV_W-1]};
        ge1    = (r1 >= {1'b0, d_reg});
        r1n    = ge1 ? DIVISOR_W'(r1 - {1'b0, d_reg}) : DIVISOR_W'(r1);
        r2     = {r1n, q_reg[DIV_W-2]};
        ge2    = (r2 >= {1'b0, d_reg});
        r2n    = ge2 ? DIVISOR_W'(r2 - {1'b0, d_reg}) : DIVISOR_W'(r2);
        q_next = {q_reg[DIV_W-3:0], ge1, ge2};
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.dividend;
            rem_reg <= '0;
            d_reg   <= req.divisor;
        end
        else if (run_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= r2n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

[sv/wspm_back.sv]
`include "assert_macros.svh"

module wspm_back #(
    parameter int WHEELS = wspm_pkg::WHEELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           avail,
    input  wspm_pkg::q_entry_t             pop_data,
    output logic                           pop,
    input  logic [wspm_pkg::PSC_W-1:0]     prescaler,
    input  logic [wspm_pkg::TEETH_W-1:0]   teeth_count,
    output wspm_pkg::div_req_t             div_req,
    input  wspm_pkg::div_rsp_t             div_rsp,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [wspm_pkg::WHEEL_W-1:0]   wheel_out,
    output logic [wspm_pkg::FREQ_W-1:0]    frequency,
    output logic [wspm_pkg::RPM_W-1:0]     speed_rpm,
    output logic                           updated,
    output logic                           stopped
);
    import wspm_pkg::*;

    localparam int IW = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TICK = 3'd1;
    localparam logic [2:0] ST_FREQ = 3'd2;
    localparam logic [2:0] ST_RPM  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    q_entry_t           ent_reg;
    div_req_t           req_reg;

    logic [FREQ_W-1:0]  freq_st_reg [WHEELS];
    logic [RPM_W-1:0]   rpm_st_reg  [WHEELS];

    logic [FREQ_W-1:0]  tick_reg;
    logic [PSC_W-1:0]   tick_psc_reg;
    logic               tick_ok_reg;
    logic [FREQ_W-1:0]  freq_new_reg;
    logic               freq_pending_reg;

    logic               out_valid_reg;
    logic [WHEEL_W-1:0] wheel_out_reg;
    logic [FREQ_W-1:0]  freq_out_reg;
    logic [RPM_W-1:0]   rpm_out_reg;
    logic               upd_reg;
    logic               stop_reg;

    logic               out_free;
    logic               tick_hit;
    logic [IW-1:0]      widx;
    logic [FREQ_W-1:0]  freq_q;
    logic [RPM_W-1:0]   freq_x60;
    logic [TEETH_W-1:0] teeth;
    logic               zero_freq;

    assign out_free  = !out_valid_reg || out_ready;
    assign tick_hit  = tick_ok_reg && (tick_psc_reg == prescaler);
    assign widx      = IW'(ent_reg.wheel);
    assign freq_q    = div_rsp.quotient[FREQ_W-1:0];
    assign freq_x60  = (RPM_W'(freq_new_reg) << 6) - (RPM_W'(freq_new_reg) << 2);
    assign teeth     = (teeth_count == '0) ? TEETH_W'(1) : teeth_count;
    assign zero_freq = (ent_reg.kind == K_OVF) && ent_reg.stopped;
    assign pop       = (state_reg == ST_IDLE) && avail;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (avail)
                begin
                    if (pop_data.kind == K_CAP_CALC)
                    begin
                        state_next = tick_hit ? ST_FREQ : ST_TICK;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_TICK:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FREQ;
                end
            end
            ST_FREQ:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_RPM;
                end
            end
            ST_RPM:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= pop_data;
        end
        if (state_reg == ST_TICK && div_rsp.done)
        begin
            tick_reg     <= div_rsp.quotient[FREQ_W-1:0];
            tick_psc_reg <= prescaler;
        end
        if (state_reg == ST_FREQ && div_rsp.done)
        begin
            freq_new_reg <= freq_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_reg       <= '0;
            tick_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            wheel_out_reg <= '0;
            freq_out_reg  <= '0;
            rpm_out_reg   <= '0;
            upd_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            for (int i = 0; i < WHEELS; i++)
            begin
                freq_st_reg[i] <= '0;
                rpm_st_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            req_reg.start <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (avail && pop_data.kind == K_CAP_CALC)
                    begin
                        req_reg.start <= 1'b1;
                        if (tick_hit)
                        begin
                            req_reg.dividend <= DIV_W'(tick_reg);
                            req_reg.divisor  <= pop_data.interval;
                        end
                        else
                        begin
                            req_reg.dividend <= DIV_W'(CLOCK_HZ);
                            req_reg.divisor  <= DIVISOR_W'(prescaler) + 1'b1;
                        end
                    end
                end
                ST_TICK:
                begin
                    if (div_rsp.done)
                    begin
                        tick_ok_reg      <= 1'b1;
                        req_reg.start    <= 1'b1;
                        req_reg.dividend <= div_rsp.quotient;
                        req_reg.divisor  <= ent_reg.interval;
                    end
                end
                ST_FREQ:
                begin
                    if (div_rsp.done)
                    begin
                        // rpm dividend is built from freq_new_reg in the next state
                        req_reg.dividend <= '0;
                    end
                end
                ST_RPM:
                begin
                    if (div_rsp.done)
                    begin
                        freq_st_reg[widx] <= freq_new_reg;
                        rpm_st_reg[widx]  <= div_rsp.quotient[RPM_W-1:0];
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        if (zero_freq)
                        begin
                            freq_st_reg[widx] <= '0;
                        end
                        out_valid_reg <= 1'b1;
                        wheel_out_reg <= ent_reg.wheel;
                        freq_out_reg  <= zero_freq ? '0 : freq_st_reg[widx];
                        rpm_out_reg   <= rpm_st_reg[widx];
                        upd_reg       <= (ent_reg.kind == K_CAP_CALC);
                        stop_reg      <= ent_reg.stopped;
                    end
                end
                default:
                begin
                    req_reg.start <= 1'b0;
                end
            endcase
            // rpm division is requested in the cycle after the frequency is latched
            if (state_reg == ST_RPM && !div_rsp.done && req_reg.dividend == '0
                && !req_reg.start && freq_pending_reg)
            begin
                req_reg.start    <= 1'b1;
                req_reg.dividend <= DIV_W'(freq_x60);
                req_reg.divisor  <= DIVISOR_W'(teeth);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_pending_reg <= 1'b0;
        end
        else if (state_reg == ST_FREQ && div_rsp.done)
        begin
            freq_pending_reg <= 1'b1;
        end
        else if (state_reg == ST_RPM)
        begin
            freq_pending_reg <= 1'b0;
        end
    end

    assign div_req   = req_reg;
    assign out_valid = out_valid_reg;
    assign wheel_out = wheel_out_reg;
    assign frequency = freq_out_reg;
    assign speed_rpm = rpm_out_reg;
    assign updated   = upd_reg;
    assign stopped   = stop_reg;

    `WSPM_ASSERT_IMPL(a_upd_not_stopped, out_valid_reg, !(upd_reg && stop_reg))
    `WSPM_ASSERT_IMPL(a_stopped_zero_freq, out_valid_reg && stop_reg, freq_out_reg == '0)
    `WSPM_ASSERT_IMPL(a_done_in_div, div_rsp.done,
        state_reg == ST_TICK || state_reg == ST_FREQ || state_reg == ST_RPM)

endmodule

[sv/wheel_speed_period_meter.sv]
// wheel speed period meter
// input channel s_*: one item per timer event; s_tuser is the event kind
// (capture edge or timer overflow), s_tdata holds the wheel and the captured count
// output channel m_*: one item per accepted event of a wheel below WHEELS, carrying
// the wheel, its stored frequency and rpm, and the updated and stopped flags;
// events for a wheel index of WHEELS or more are taken and give no item
// cfg_we/cfg_index/cfg_data write timer period, prescaler and teeth count, idle only
// the front takes an event per cycle while its four-entry queue has room, computes
// the interval and keeps the per-wheel overflow count and last capture
// the back runs one shared divider at two quotient bits per cycle
// a capture that yields a new frequency holds the back for a divide by the interval
// and then the rpm divide, with a tick-rate divide first when none was done yet or
// the prescaler changed since the last one; overflow and no-update events skip the divider
// reset clears all wheel state to zero and loads the register defaults
// a stalled receiver holds the output register; the back waits on it, the queue
// fills and s_tready falls when the queue is full
module wheel_speed_period_meter #(
    parameter int WHEELS = wspm_pkg::WHEELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [wspm_pkg::S_DATA_W-1:0]        s_tdata,   // wheel, capture_value, zero pad
    input  logic                                 s_tuser,   // func
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [wspm_pkg::M_DATA_W-1:0]        m_tdata,   // wheel_out, frequency, speed_rpm, pad
    output logic [1:0]                           m_tuser,   // updated, stopped
    input  logic                                 cfg_we,
    input  logic [wspm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wspm_pkg::CFG_W-1:0]           cfg_data
);
    import wspm_pkg::*;

    logic [PERIOD_W-1:0] period_reg;
    logic [PSC_W-1:0]    psc_reg;
    logic [TEETH_W-1:0]  teeth_reg;

    logic                push;
    q_entry_t            push_data;
    logic                full;
    logic                pop;
    logic                avail;
    q_entry_t            pop_data;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic [WHEEL_W-1:0]  wheel_out;
    logic [FREQ_W-1:0]   frequency;
    logic [RPM_W-1:0]    speed_rpm;
    logic                updated;
    logic                stopped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            psc_reg    <= PSC_RST;
            teeth_reg  <= TEETH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMER_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                REG_PRESCALER:    psc_reg    <= cfg_data[PSC_W-1:0];
                REG_TEETH_COUNT:  teeth_reg  <= cfg_data[TEETH_W-1:0];
                default:          period_reg <= period_reg;
            endcase
        end
    end

    wspm_front #(.WHEELS(WHEELS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .func          (s_tuser),
        .wheel         (s_tdata[WHEEL_W-1:0]),
        .capture_value (s_tdata[WHEEL_W+CAP_W-1:WHEEL_W]),
        .timer_period  (period_reg),
        .push          (push),
        .push_data     (push_data),
        .full          (full)
    );

    wspm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .avail     (avail),
        .pop_data  (pop_data)
    );

    wspm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    wspm_back #(.WHEELS(WHEELS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .avail       (avail),
        .pop_data    (pop_data),
        .pop         (pop),
        .prescaler   (psc_reg),
        .teeth_count (teeth_reg),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .wheel_out   (wheel_out),
        .frequency   (frequency),
        .speed_rpm   (speed_rpm),
        .updated     (updated),
        .stopped     (stopped)
    );

    assign m_tdata = {(M_DATA_W - WHEEL_W - FREQ_W - RPM_W)'(0), speed_rpm, frequency, wheel_out};
    assign m_tuser = {stopped, updated};

endmodule

[test/wheel_report_checker.sv]
`timescale 1ns / 100ps

module wheel_report_checker
    import wspm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_DATA_W-1:0]  m_tdata,
    input  logic [1:0]           m_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatch_count,
    output int                   reports_pending
);

    typedef struct packed {
        logic [WHEEL_W-1:0] wheel;
        logic [FREQ_W-1:0]  frequency;
        logic [RPM_W-1:0]   speed_rpm;
        logic               updated;
        logic               stopped;
    } wheel_report_t;

    wheel_report_t expected_reports[$];

    logic [PERIOD_W-1:0] period_cfg;
    logic [PSC_W-1:0]    psc_cfg;
    logic [TEETH_W-1:0]  teeth_cfg;

    logic [CAP_W-1:0]  last_cap [WHEELS_DEF];
    logic [1:0]        ovf_cnt  [WHEELS_DEF];
    logic [FREQ_W-1:0] freq_now [WHEELS_DEF];
    logic [RPM_W-1:0]  rpm_now  [WHEELS_DEF];

    function automatic wheel_report_t advance_wheel(logic func, logic [WHEEL_W-1:0] w,
                                                    logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] interval;
        logic [63:0]      tick;
        logic [63:0]      freq_full;
        logic [63:0]      rpm_full;
        logic [63:0]      teeth;
        logic             upd;
        wheel_report_t    rep;
        upd = 1'b0;
        if (func == FUNC_OVERFLOW)
        begin
            if (ovf_cnt[w] < OVC_MAX)
                ovf_cnt[w] = ovf_cnt[w] + 2'd1;
            if (ovf_cnt[w] >= STOP_LIMIT)
                freq_now[w] = '0;
        end
        else
        begin
            interval = cap + {30'd0, ovf_cnt[w]} * period_cfg - last_cap[w];
            if (interval != '0 && ovf_cnt[w] < STOP_LIMIT)
            begin
                teeth = (teeth_cfg == '0) ? 64'd1 : {56'd0, teeth_cfg};
                tick = {37'd0, CLOCK_HZ} / ({48'd0, psc_cfg} + 64'd1);
                freq_full = tick / {32'd0, interval};
                freq_now[w] = freq_full[FREQ_W-1:0];
                rpm_full = ({37'd0, freq_now[w]} * 64'd60) / teeth;
                rpm_now[w] = rpm_full[RPM_W-1:0];
                upd = 1'b1;
            end
            ovf_cnt[w] = 2'd0;
            last_cap[w] = cap;
        end
        rep.wheel = w;
        rep.frequency = freq_now[w];
        rep.speed_rpm = rpm_now[w];
        rep.updated = upd;
        rep.stopped = (ovf_cnt[w] >= STOP_LIMIT);
        return rep;
    endfunction

    task automatic check_field(string name, logic [WHEEL_W-1:0] w, logic [63:0] exp_val,
                               logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t ns: wheel %0d %s expected %0d got %0d",
                     $time, w, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        wheel_report_t exp_rep;
        wheel_report_t got_rep;
        if (!rst_n)
        begin
            expected_reports.delete();
            mismatch_count = 0;
            period_cfg = PERIOD_RST;
            psc_cfg = PSC_RST;
            teeth_cfg = TEETH_RST;
            for (int i = 0; i < WHEELS_DEF; i++)
            begin
                last_cap[i] = '0;
                ovf_cnt[i] = '0;
                freq_now[i] = '0;
                rpm_now[i] = '0;
            end
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_rep.wheel = m_tdata[WHEEL_W-1:0];
                got_rep.frequency = m_tdata[WHEEL_W +: FREQ_W];
                got_rep.speed_rpm = m_tdata[WHEEL_W+FREQ_W +: RPM_W];
                got_rep.updated = m_tuser[0];
                got_rep.stopped = m_tuser[1];
                if (expected_reports.size() == 0)
                begin
                    $display("%0t ns: unexpected item, wheel %0d frequency %0d rpm %0d",
                             $time, got_rep.wheel, got_rep.frequency, got_rep.speed_rpm);
                    mismatch_count++;
                end
                else
                begin
                    exp_rep = expected_reports.pop_front();
                    check_field("wheel_out", exp_rep.wheel, 64'(exp_rep.wheel),
                                64'(got_rep.wheel));
                    check_field("frequency", exp_rep.wheel, 64'(exp_rep.frequency),
                                64'(got_rep.frequency));
                    check_field("speed_rpm", exp_rep.wheel, 64'(exp_rep.speed_rpm),
                                64'(got_rep.speed_rpm));
                    check_field("updated", exp_rep.wheel, 64'(exp_rep.updated),
                                64'(got_rep.updated));
                    check_field("stopped", exp_rep.wheel, 64'(exp_rep.stopped),
                                64'(got_rep.stopped));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TIMER_PERIOD: period_cfg = cfg_data[PERIOD_W-1:0];
                    REG_PRESCALER:    psc_cfg = cfg_data[PSC_W-1:0];
                    REG_TEETH_COUNT:  teeth_cfg = cfg_data[TEETH_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tdata[WHEEL_W-1:0] < WHEELS_DEF)
                    expected_reports.push_back(advance_wheel(s_tuser, s_tdata[WHEEL_W-1:0],
                                                             s_tdata[WHEEL_W +: CAP_W]));
            end
        end
        reports_pending = expected_reports.size();
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import wspm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 190;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   mismatch_count;
    int                   reports_pending;

    int send_idle;
    int recv_idle;
    int hold_left;
    int stall_cycles;

    logic [PERIOD_W-1:0] cur_period;
    logic [CAP_W-1:0]    sent_last [WHEELS_DEF];
    logic [1:0]          sent_ovf  [WHEELS_DEF];

    wheel_speed_period_meter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wheel_report_checker report_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .reports_pending (reports_pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: a long hold-off while one is pending, else random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_event(logic func, logic [WHEEL_W-1:0] w, logic [CAP_W-1:0] cap);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {6'd0, cap, w};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (func == FUNC_OVERFLOW)
        begin
            if (sent_ovf[w] < OVC_MAX)
                sent_ovf[w] = sent_ovf[w] + 2'd1;
        end
        else
        begin
            sent_last[w] = cap;
            sent_ovf[w] = 2'd0;
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (reports_pending != 0)
            @(negedge clk);
    endtask

    task automatic program_regs(logic [PERIOD_W-1:0] period, logic [PSC_W-1:0] psc,
                                logic [TEETH_W-1:0] teeth);
        cfg_we <= 1'b1;
        cfg_index <= REG_TIMER_PERIOD;
        cfg_data <= period;
        @(negedge clk);
        cfg_index <= REG_PRESCALER;
        cfg_data <= {16'd0, psc};
        @(negedge clk);
        cfg_index <= REG_TEETH_COUNT;
        cfg_data <= {24'd0, teeth};
        @(negedge clk);
        cfg_index <= REG_SPARE;
        cfg_data <= $urandom;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_period = period;
    endtask

    // mostly captures that follow the wheel's timeline, some overflows and noise
    task automatic random_event();
        logic [WHEEL_W-1:0] w;
        logic [CAP_W-1:0]   delta;
        int                 pick;
        w = WHEEL_W'($urandom_range(3));
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0: delta = $urandom_range(1, 200);
            1: delta = $urandom_range(1, 100000);
            2: delta = $urandom_range(1, 20000000);
            default: delta = $urandom;
        endcase
        if (pick < 14)
            send_event(FUNC_OVERFLOW, w, $urandom);
        else if (pick < 22)
            send_event(FUNC_CAPTURE, w, $urandom);
        else if (pick < 26)
            send_event(FUNC_CAPTURE, w, sent_last[w] - {30'd0, sent_ovf[w]} * cur_period);
        else
            send_event(FUNC_CAPTURE, w,
                       sent_last[w] + delta - {30'd0, sent_ovf[w]} * cur_period);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_CAPTURE;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TIMER_PERIOD;
        cfg_data = '0;
        send_idle = 0;
        recv_idle = 0;
        hold_left = 0;
        stall_cycles = 0;
        cur_period = PERIOD_RST;
        for (int i = 0; i < WHEELS_DEF; i++)
        begin
            sent_last[i] = '0;
            sent_ovf[i] = '0;
        end
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register defaults
        send_event(FUNC_CAPTURE, 2'd0, 32'd100);
        send_event(FUNC_CAPTURE, 2'd0, 32'd100);
        send_event(FUNC_OVERFLOW, 2'd0, 32'd0);
        send_event(FUNC_CAPTURE, 2'd0, 32'd50);
        repeat (4) send_event(FUNC_OVERFLOW, 2'd0, 32'hFFFF_FFFF);
        send_event(FUNC_CAPTURE, 2'd0, 32'd1000);
        send_event(FUNC_CAPTURE, 2'd0, 32'hFFFF_FFFF);
        send_event(FUNC_CAPTURE, 2'd1, 32'd1);
        send_event(FUNC_CAPTURE, 2'd2, 32'hFFFF_FFFF);
        send_event(FUNC_OVERFLOW, 2'd2, 32'd0);
        send_event(FUNC_CAPTURE, 2'd2, 32'hFFFF_0000);
        send_event(FUNC_CAPTURE, 2'd3, 32'd96);
        send_event(FUNC_OVERFLOW, 2'd3, 32'd0);
        send_event(FUNC_OVERFLOW, 2'd3, 32'd0);
        send_event(FUNC_CAPTURE, 2'd3, 32'd200);
        wait_drain();

        // largest period, prescaler and teeth
        program_regs(32'hFFFF_FFFF, 16'hFFFF, 8'd255);
        send_event(FUNC_CAPTURE, 2'd0, 32'd1);
        send_event(FUNC_OVERFLOW, 2'd1, 32'd0);
        send_event(FUNC_CAPTURE, 2'd1, 32'd0);
        wait_drain();

        // zero period and zero teeth
        program_regs(32'd0, 16'd0, 8'd0);
        send_event(FUNC_CAPTURE, 2'd2, 32'hFFFF_0001);
        send_event(FUNC_OVERFLOW, 2'd3, 32'd0);
        send_event(FUNC_CAPTURE, 2'd3, 32'd300);
        wait_drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: program_regs(PERIOD_RST, PSC_RST, TEETH_RST);
                1: program_regs(32'hFFFF_FFFF, 16'hFFFF, 8'd255);
                2: program_regs($urandom, PSC_W'($urandom_range(65535)),
                                TEETH_W'($urandom_range(1, 255)));
                3: program_regs(32'd1000, 16'd7, 8'd48);
                4: program_regs(32'd0, 16'd1, 8'd0);
                default: program_regs($urandom, PSC_W'($urandom_range(65535)),
                                      TEETH_W'($urandom_range(255)));
            endcase
            if (p < 2)
            begin
                send_idle = 25;
                recv_idle = 54;
            end
            else if (p < 4)
            begin
                send_idle = 54;
                recv_idle = 25;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ((p == 1 || p == 4) && i == 60)
                    hold_left = HOLD_CYCLES;
                if (i == 120)
                    wait_drain();
                random_event();
            end
            wait_drain();
        end

        repeat (100) @(negedge clk);
        if (reports_pending != 0)
            $display("%0t ns: %0d expected items never arrived", $time, reports_pending);
        if (mismatch_count == 0 && reports_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/wspm_pkg.sv
sv/wspm_fifo.sv
sv/wspm_front.sv
sv/wspm_div.sv
sv/wspm_back.sv
sv/wheel_speed_period_meter.sv
test/wheel_report_checker.sv
test/testbench.sv
